@@ design/dtd_pkg.sv @@
package dtd_pkg;

    // Request codes
    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_POP   = 2'd1,
        REQ_MARK  = 2'd2,
        REQ_CLEAR = 2'd3
    } req_t;

    localparam int IdentW = 5;
    localparam int MaskW  = 32;

    // Input beat
    typedef struct packed {
        req_t                req_type;
        logic [IdentW-1:0]   task_ident;
        logic [MaskW-1:0]    parent_mask;
    } req_beat_t;

    // Output beat
    typedef struct packed {
        logic                task_valid;
        logic [IdentW-1:0]   out_ident;
        logic                last_task;
        logic                table_full;
    } rsp_beat_t;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic [IdentW-1:0]   ident;
        logic [MaskW-1:0]    parents;
    } entry_t;

endpackage

@@ design/dtd_if.sv @@
interface dtd_req_if;
    import dtd_pkg::*;

    logic      valid;
    logic      ready;
    req_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dtd_rsp_if;
    import dtd_pkg::*;

    logic      valid;
    logic      ready;
    rsp_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/dtd_ram.sv @@
module dtd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/dependency_aware_task_dispatcher_core.sv @@
// Channel  | Modport | Payload                                        | Beat
// ---------+---------+------------------------------------------------+------------------------
// task_req | sink    | req_type, task_ident, parent_mask              | one request
// task_rsp | source  | task_valid, out_ident, last_task, table_full   | one result per request
//
// Steps per request, from the accept state up to the result register: load, mark
// done, clear and a pop past the end go from idle straight to the result state.
// A pop reads, then checks, each entry from the dispatch position on; the first ready
// one is written to the dispatch position and the displaced entry to its slot before
// the result state; if none is ready below the count, no task is returned. The table
// RAM has one read port with registered data, so each entry is read, then checked.
// Reset clears count, dispatch position, done flags and handshake state; the table
// itself is not cleared, only entries below the count are ever read.
// A finished result waits in the output register; the next request is taken meanwhile
// and its result is held back until the output register frees up.
module dependency_aware_task_dispatcher_core #(
    parameter int MAX_TASKS = 32
) (
    input logic     clk,
    input logic     rst_n,
    dtd_req_if.sink   task_req,
    dtd_rsp_if.source task_rsp
);
    import dtd_pkg::*;

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TASKS);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_CHK  = 6'b000100,
        S_WR1  = 6'b001000,
        S_WR2  = 6'b010000,
        S_RESP = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic [MaskW-1:0] done_reg, done_next;
    entry_t           pos_data_reg, pos_data_next;
    entry_t           found_reg, found_next;
    rsp_beat_t        res_reg, res_next;
    logic             out_valid_reg, out_valid_next;
    rsp_beat_t        out_data_reg, out_data_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [$bits(entry_t)-1:0] ram_rdata;
    entry_t           rd_entry;
    logic             in_acc;
    logic             entry_ready;

    // Task table
    dtd_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_raddr   = scan_reg[IDX_W-1:0];
    assign rd_entry    = entry_t'(ram_rdata);
    assign entry_ready = (rd_entry.parents & ~done_reg) == '0;

    assign task_req.ready = (state_reg == S_IDLE);
    assign in_acc         = task_req.valid && task_req.ready;

    assign task_rsp.valid = out_valid_reg;
    assign task_rsp.data  = out_data_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        scan_next      = scan_reg;
        done_next      = done_reg;
        pos_data_next  = pos_data_reg;
        found_next     = found_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[IDX_W-1:0];
        ram_wdata      = entry_t'{ident: task_req.data.task_ident,
                                  parents: task_req.data.parent_mask};

        // output register drains independently
        if (out_valid_reg && task_rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    res_next   = '0;
                    state_next = S_RESP;
                    unique case (task_req.data.req_type)
                        REQ_LOAD:
                        begin
                            if (count_reg == CNT_MAX)
                            begin
                                res_next.table_full = 1'b1;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CNT_ONE;
                            end
                        end
                        REQ_POP:
                        begin
                            if (pos_reg != count_reg)
                            begin
                                scan_next  = pos_reg;
                                state_next = S_RD;
                            end
                        end
                        REQ_MARK:
                        begin
                            done_next = done_reg | (MaskW'(1) << task_req.data.task_ident);
                        end
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                            pos_next   = '0;
                            done_next  = '0;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (scan_reg == pos_reg)
                begin
                    pos_data_next = rd_entry;
                end
                if (entry_ready)
                begin
                    found_next = rd_entry;
                    state_next = S_WR1;
                end
                else if (scan_reg + CNT_ONE == count_reg)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    scan_next  = scan_reg + CNT_ONE;
                    state_next = S_RD;
                end
            end
            S_WR1:
            begin
                // ready task moves to the dispatch position
                ram_we     = 1'b1;
                ram_waddr  = pos_reg[IDX_W-1:0];
                ram_wdata  = found_reg;
                state_next = S_WR2;
            end
            S_WR2:
            begin
                // displaced entry takes the vacated slot
                ram_we              = 1'b1;
                ram_waddr           = scan_reg[IDX_W-1:0];
                ram_wdata           = pos_data_reg;
                pos_next            = pos_reg + CNT_ONE;
                res_next.task_valid = 1'b1;
                res_next.out_ident  = found_reg.ident;
                res_next.last_task  = (pos_reg + CNT_ONE) == count_reg;
                state_next          = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || task_rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pos_reg       <= '0;
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        scan_reg     <= scan_next;
        pos_data_reg <= pos_data_next;
        found_reg    <= found_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

`ifndef ASSERT_OFF
    a_pos_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= count_reg)
        else $error("dispatch position beyond entry count");

    a_count_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("entry count beyond table size");

    a_last_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.last_task) |-> out_data_reg.task_valid)
        else $error("last_task without a dispatched task");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && task_req.data.req_type == REQ_CLEAR)
            |=> (count_reg == '0 && pos_reg == '0 && done_reg == '0))
        else $error("clear left state behind");
`endif

endmodule
